// File: sv/assert_macros.svh
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define BSC_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication
`define BSC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// File: sv/bsc_pkg.sv
`default_nettype none
package bsc_pkg;

  typedef struct packed {
    logic        kind;
    logic [18:0] raw_value;
  } in_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [27:0] temperature_tenths;
    logic signed [31:0] baro_pressure;
    logic               div_zero;
  } out_t;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_AC1_AC2 = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_AC3_AC4 = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_AC5_AC6 = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_B1_B2   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MC_MD   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OSS     = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_STEP = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  // Sequencer program steps
  localparam logic [3:0] PC_T0  = 4'd0;
  localparam logic [3:0] PC_T1  = 4'd1;
  localparam logic [3:0] PC_T2  = 4'd2;
  localparam logic [3:0] PC_P0  = 4'd3;
  localparam logic [3:0] PC_P1  = 4'd4;
  localparam logic [3:0] PC_P2  = 4'd5;
  localparam logic [3:0] PC_P3  = 4'd6;
  localparam logic [3:0] PC_P4  = 4'd7;
  localparam logic [3:0] PC_P5  = 4'd8;
  localparam logic [3:0] PC_P6  = 4'd9;
  localparam logic [3:0] PC_P7  = 4'd10;
  localparam logic [3:0] PC_P8  = 4'd11;
  localparam logic [3:0] PC_P9  = 4'd12;
  localparam logic [3:0] PC_P10 = 4'd13;
  localparam logic [3:0] PC_P11 = 4'd14;

  localparam logic [31:0] C_4000  = 32'd4000;
  localparam logic [31:0] C_3038  = 32'd3038;
  localparam logic [31:0] C_M7357 = 32'hFFFF_E343;
  localparam logic [31:0] C_3791  = 32'd3791;
  localparam logic [31:0] C_50000 = 32'd50000;
  localparam logic [31:0] C_32768 = 32'd32768;

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
    asr32 = 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] sext16(input logic [15:0] v);
    sext16 = {{16{v[15]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: sv/baro_sensor_compensation_core.sv
// Barometric sensor compensation core.
// Input channel (in_valid_i / in_stall_o / in_data_i): kind 0 carries a raw
// temperature reading, kind 1 a raw pressure reading. Output channel
// (out_valid_o / out_stall_i / out_data_o) returns one result per item.
// Coefficients are written through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write them only while idle, which the block itself does not enforce.
// All arithmetic runs through one radix-4 shift-add multiplier and one restoring
// divider, each started from an issue step of a small sequencer. A temperature
// item takes one product and one quotient; a pressure item ten products and one
// quotient. A zero divisor skips the division. After the result is loaded into
// the output register the core returns to idle and can take the next item.
// One item is in work at a time; in_stall_o is high from acceptance until the
// result is moved into the output register. A finished result waits in that
// register while the next item is accepted; if the receiver stalls and a second
// result is ready, the sequencer holds until the first transfer completes.
// Reset clears coefficients, the stored b5 term, the state and the output valid.
`default_nettype none
`include "assert_macros.svh"
module baro_sensor_compensation_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire bsc_pkg::in_t              in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output bsc_pkg::out_t                  out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [bsc_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [31:0]               cfg_wdata_i
);

  bsc_pkg::state_e state_q, state_d;
  logic [3:0]  pc_q, pc_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        kind_q, kind_d;
  logic [18:0] raw_q, raw_d;
  logic [31:0] b5_q, b5_d, b6_q, b6_d, sq_q, sq_d, b3_q, b3_d, b4_q, b4_d;
  logic [31:0] p_q, p_d, ta_q, ta_d, res_q, res_d;
  logic [31:0] mca_q, mca_d, mpl_q, mpl_d, acc_q, acc_d;
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic        neg_q, neg_d, post2_q, post2_d, dz_q, dz_d;
  logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
  logic [1:0]  oss_q;
  logic        out_valid_q, out_valid_d;
  bsc_pkg::out_t out_q, out_d;

  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = bsc_pkg::sext16(ac12_q[31:16]);
  assign ac2 = bsc_pkg::sext16(ac12_q[15:0]);
  assign ac3 = bsc_pkg::sext16(ac34_q[31:16]);
  assign ac4 = {16'd0, ac34_q[15:0]};
  assign ac5 = {16'd0, ac56_q[31:16]};
  assign ac6 = {16'd0, ac56_q[15:0]};
  assign b1  = bsc_pkg::sext16(b12_q[31:16]);
  assign b2  = bsc_pkg::sext16(b12_q[15:0]);
  assign mc  = bsc_pkg::sext16(mcmd_q[31:16]);
  assign md  = bsc_pkg::sext16(mcmd_q[15:0]);

  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    logic [31:0] x1, x3, dvd, dvr, v, q, pp, part;
    logic [32:0] r;
    x1 = '0; x3 = '0; dvd = '0; dvr = '0; v = '0; q = '0; pp = '0;
    part = '0; r = '0;
    state_d = state_q; pc_d = pc_q; cnt_d = cnt_q; kind_d = kind_q; raw_d = raw_q;
    b5_d = b5_q; b6_d = b6_q; sq_d = sq_q; b3_d = b3_q; b4_d = b4_q;
    p_d = p_q; ta_d = ta_q; res_d = res_q;
    mca_d = mca_q; mpl_d = mpl_q; acc_d = acc_q;
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q;
    neg_d = neg_q; post2_d = post2_q; dz_d = dz_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      bsc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_data_i.kind;
          raw_d   = in_data_i.raw_value;
          dz_d    = 1'b0;
          pc_d    = in_data_i.kind ? bsc_pkg::PC_P0 : bsc_pkg::PC_T0;
          state_d = bsc_pkg::ST_STEP;
        end
      end
      bsc_pkg::ST_MUL: begin
        case (mpl_q[1:0])
          2'd0:    part = '0;
          2'd1:    part = mca_q;
          2'd2:    part = {mca_q[30:0], 1'b0};
          default: part = mca_q + {mca_q[30:0], 1'b0};
        endcase
        acc_d = acc_q + part;
        mca_d = {mca_q[29:0], 2'b00};
        mpl_d = {2'b00, mpl_q[31:2]};
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = bsc_pkg::ST_STEP;
      end
      bsc_pkg::ST_DIV: begin
        r = {rem_q, quo_q[31]};
        if (r >= {1'b0, dvs_q}) begin
          rem_d = 32'(r - {1'b0, dvs_q});
          quo_d = {quo_q[30:0], 1'b1};
        end else begin
          rem_d = r[31:0];
          quo_d = {quo_q[30:0], 1'b0};
        end
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) state_d = bsc_pkg::ST_STEP;
      end
      bsc_pkg::ST_FIN: begin
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_d.result_kind      = kind_q;
          out_d.temperature_tenths = kind_q ? 28'sd0 : $signed(res_q[27:0]);
          out_d.baro_pressure    = kind_q ? $signed(res_q) : 32'sd0;
          out_d.div_zero         = dz_q;
          state_d                = bsc_pkg::ST_IDLE;
        end
      end
      bsc_pkg::ST_STEP: begin
        pc_d = pc_q + 4'd1;
        // Default: issue a multiply; steps override operands or the next state
        state_d = bsc_pkg::ST_MUL;
        cnt_d   = 5'd15;
        acc_d   = '0;
        case (pc_q)
          bsc_pkg::PC_T0: begin
            mca_d = {13'd0, raw_q} - ac6;
            mpl_d = ac5;
          end
          bsc_pkg::PC_T1: begin
            x1   = bsc_pkg::asr32(acc_q, 5'd15);
            ta_d = x1;
            dvd  = {mc[20:0], 11'd0};
            dvr  = x1 + md;
            neg_d = dvd[31] ^ dvr[31];
            rem_d = '0;
            quo_d = dvd[31] ? 32'(0 - dvd) : dvd;
            dvs_d = dvr[31] ? 32'(0 - dvr) : dvr;
            cnt_d = 5'd31;
            state_d = bsc_pkg::ST_DIV;
            if (dvr == '0) begin
              dz_d = 1'b1; quo_d = '0; neg_d = 1'b0; state_d = bsc_pkg::ST_STEP;
            end else if (dvd == 32'h8000_0000 && dvr == 32'hFFFF_FFFF) begin
              quo_d = 32'h8000_0000; neg_d = 1'b0; state_d = bsc_pkg::ST_STEP;
            end
          end
          bsc_pkg::PC_T2: begin
            q     = neg_q ? 32'(0 - quo_q) : quo_q;
            b5_d  = ta_q + q;
            res_d = bsc_pkg::asr32(ta_q + q + 32'd8, 5'd4);
            state_d = bsc_pkg::ST_FIN;
          end
          bsc_pkg::PC_P0: begin
            b6_d  = b5_q - bsc_pkg::C_4000;
            mca_d = b5_q - bsc_pkg::C_4000;
            mpl_d = b5_q - bsc_pkg::C_4000;
          end
          bsc_pkg::PC_P1: begin
            sq_d  = bsc_pkg::asr32(acc_q, 5'd12);
            mca_d = b2;
            mpl_d = bsc_pkg::asr32(acc_q, 5'd12);
          end
          bsc_pkg::PC_P2: begin
            ta_d  = bsc_pkg::asr32(acc_q, 5'd11);
            mca_d = ac2;
            mpl_d = b6_q;
          end
          bsc_pkg::PC_P3: begin
            x3 = ta_q + bsc_pkg::asr32(acc_q, 5'd11);
            v  = (({ac1[29:0], 2'b00} + x3) << oss_q) + 32'd2;
            q  = (v[31] ? 32'(0 - v) : v) >> 2;
            b3_d  = v[31] ? 32'(0 - q) : q;
            mca_d = ac3;
            mpl_d = b6_q;
          end
          bsc_pkg::PC_P4: begin
            ta_d  = bsc_pkg::asr32(acc_q, 5'd13);
            mca_d = b1;
            mpl_d = sq_q;
          end
          bsc_pkg::PC_P5: begin
            x3 = bsc_pkg::asr32(ta_q + bsc_pkg::asr32(acc_q, 5'd16) + 32'd2, 5'd2);
            mca_d = ac4;
            mpl_d = x3 + bsc_pkg::C_32768;
          end
          bsc_pkg::PC_P6: begin
            b4_d  = acc_q >> 15;
            mca_d = {13'd0, raw_q} - b3_q;
            mpl_d = bsc_pkg::C_50000 >> oss_q;
          end
          bsc_pkg::PC_P7: begin
            rem_d = '0;
            dvs_d = b4_q;
            cnt_d = 5'd31;
            state_d = bsc_pkg::ST_DIV;
            post2_d = acc_q[31];
            quo_d   = acc_q[31] ? acc_q : {acc_q[30:0], 1'b0};
            if (b4_q == '0) begin
              dz_d = 1'b1; quo_d = '0; post2_d = 1'b0; state_d = bsc_pkg::ST_STEP;
            end
          end
          bsc_pkg::PC_P8: begin
            pp    = post2_q ? {quo_q[30:0], 1'b0} : quo_q;
            p_d   = pp;
            mca_d = bsc_pkg::asr32(pp, 5'd8);
            mpl_d = bsc_pkg::asr32(pp, 5'd8);
          end
          bsc_pkg::PC_P9: begin
            mca_d = acc_q;
            mpl_d = bsc_pkg::C_3038;
          end
          bsc_pkg::PC_P10: begin
            ta_d  = bsc_pkg::asr32(acc_q, 5'd16);
            mca_d = bsc_pkg::C_M7357;
            mpl_d = p_q;
          end
          bsc_pkg::PC_P11: begin
            x1 = ta_q + bsc_pkg::asr32(acc_q, 5'd16) + bsc_pkg::C_3791;
            res_d = p_q + bsc_pkg::asr32(x1, 5'd4);
            state_d = bsc_pkg::ST_FIN;
          end
          default: state_d = bsc_pkg::ST_FIN;
        endcase
      end
      default: state_d = bsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      b5_q        <= '0;
      ac12_q      <= '0;
      ac34_q      <= '0;
      ac56_q      <= '0;
      b12_q       <= '0;
      mcmd_q      <= '0;
      oss_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      b5_q        <= b5_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bsc_pkg::CFG_AC1_AC2: ac12_q <= cfg_wdata_i;
          bsc_pkg::CFG_AC3_AC4: ac34_q <= cfg_wdata_i;
          bsc_pkg::CFG_AC5_AC6: ac56_q <= cfg_wdata_i;
          bsc_pkg::CFG_B1_B2:   b12_q  <= cfg_wdata_i;
          bsc_pkg::CFG_MC_MD:   mcmd_q <= cfg_wdata_i;
          bsc_pkg::CFG_OSS:     oss_q  <= cfg_wdata_i[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pc_q <= pc_d; cnt_q <= cnt_d; kind_q <= kind_d; raw_q <= raw_d;
    b6_q <= b6_d; sq_q <= sq_d; b3_q <= b3_d; b4_q <= b4_d;
    p_q <= p_d; ta_q <= ta_d; res_q <= res_d;
    mca_q <= mca_d; mpl_q <= mpl_d; acc_q <= acc_d;
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
    neg_q <= neg_d; post2_q <= post2_d; dz_q <= dz_d;
    out_q <= out_d;
  end

  assign in_stall_o  = (state_q != bsc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BSC_ASSERT_CLK(a_accept_busy, (in_valid_i && !in_stall_o) |=> in_stall_o, "accept did not start work")
  `BSC_ASSERT_CLK(a_mul_end, (state_q == bsc_pkg::ST_MUL && cnt_q == 5'd0) |=> (state_q == bsc_pkg::ST_STEP), "multiply did not end")
  `BSC_ASSERT_IMPL(a_zero_other, out_valid_o, (out_data_o.result_kind ? (out_data_o.temperature_tenths == 28'sd0) : (out_data_o.baro_pressure == 32'sd0)), "unused result field not zero")

endmodule
`default_nettype wire
